// ===== hdl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int unsigned DigitWidth = 4;
  localparam int unsigned CharWidth  = 6;

  // ASCII code of the character '0'.
  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new value and clear the digit register
    logic dabble;  // one add-3 and shift step of the conversion
    logic skip;    // drop a leading zero digit
    logic emit;    // send the top digit out and drop it
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic top_zero;  // the most significant digit is zero
  } dp_sts_t;

endpackage

// ===== hdl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Usage: drive value_i and raise start while busy is low; the value is
// taken in at that clock edge and busy rises in the next cycle.
// The block converts the value with a shift and add-3 loop over the input
// bits, then drops leading zero digits, then sends one digit per cycle,
// most significant first. Each character appears on ascii_char_o for
// exactly one cycle with result_valid_o high; last_digit_o is high on the
// units digit, which ends the transfer run. A value of zero gives a single
// '0'. Before the first character come the conversion, the skipping of
// leading zeros, a step of its own in which the controller turns from
// skipping to sending, and the output register. Busy stays high from the
// accepting edge until the last character is registered, and no new value
// is taken while busy is high. A new start is taken in the cycle in which
// the last character is shown.
// The receiver cannot stall the block: it must take each character in the
// cycle it is shown. Reset clears the controller and the valid strobe.
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [VALUE_WIDTH-1:0]         value_i,
  output logic [b2da_pkg::CharWidth-1:0] ascii_char_o,
  output logic                           last_digit_o,
  output logic                           result_valid_o
);
  import b2da_pkg::*;

  // Decimal digits of the largest value: floor(W * log10(2)) + 1.
  localparam int unsigned NumDigits = ((VALUE_WIDTH * 1233) >> 12) + 1;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    last_dig;

  b2da_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NumDigits)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd),
    .last_o(last_dig)
  );

  b2da_dpath #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NumDigits)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .last_i        (last_dig),
    .sts_o         (sts),
    .ascii_char_o  (ascii_char_o),
    .last_digit_o  (last_digit_o),
    .result_valid_o(result_valid_o)
  );

endmodule

// ===== hdl/b2da_dpath.sv =====
// Datapath: binary shift register, BCD digit register and output registers.
module b2da_dpath #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NUM_DIGITS  = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [VALUE_WIDTH-1:0]              value_i,
  input  b2da_pkg::dp_cmd_t                   cmd_i,
  input  logic                                last_i,
  output b2da_pkg::dp_sts_t                   sts_o,
  output logic [b2da_pkg::CharWidth-1:0]      ascii_char_o,
  output logic                                last_digit_o,
  output logic                                result_valid_o
);
  import b2da_pkg::*;

  localparam int unsigned BcdWidth = NUM_DIGITS * DigitWidth;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]    bcd_q, bcd_d;
  logic [BcdWidth-1:0]    bcd_adj;
  logic [DigitWidth-1:0]  top_digit;
  logic [CharWidth-1:0]   char_q, char_d;
  logic                   last_q, last_d;
  logic                   valid_q;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DigitWidth +: DigitWidth] >= 4'd5) begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth] + 4'd3;
      end else begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth];
      end
    end
  end

  assign top_digit       = bcd_q[BcdWidth-1 -: DigitWidth];
  assign sts_o.top_zero  = (top_digit == '0);

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
    end else if (cmd_i.dabble) begin
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[VALUE_WIDTH-1]};
    end else if (cmd_i.skip || cmd_i.emit) begin
      bcd_d = {bcd_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
    end
    if (cmd_i.emit) begin
      char_d = AsciiZero + {{(CharWidth-DigitWidth){1'b0}}, top_digit};
      last_d = last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign ascii_char_o   = char_q;
  assign last_digit_o   = last_q;
  assign result_valid_o = valid_q;

endmodule

// ===== hdl/b2da_ctrl.sv =====
// Controller: sequences conversion steps, leading zero skipping and digit output.
module b2da_ctrl #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NUM_DIGITS  = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  b2da_pkg::dp_sts_t sts_i,
  output b2da_pkg::dp_cmd_t cmd_o,
  output logic              last_o
);
  import b2da_pkg::*;

  localparam int unsigned BitCntWidth = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned DigCntWidth = $clog2(NUM_DIGITS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [BitCntWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntWidth-1:0] dig_cnt_q, dig_cnt_d;
  logic                   last_dig;

  assign last_dig = (dig_cnt_q == DigCntWidth'(1));

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    cmd_o     = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = BitCntWidth'(VALUE_WIDTH - 1);
          dig_cnt_d  = DigCntWidth'(NUM_DIGITS);
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.dabble = 1'b1;
        bit_cnt_d    = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        // The units digit is always shown, even when it is zero.
        if (sts_i.top_zero && !last_dig) begin
          cmd_o.skip = 1'b1;
          dig_cnt_d  = dig_cnt_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        dig_cnt_d  = dig_cnt_q - 1'b1;
        if (last_dig) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign last_o = last_dig;

endmodule

// ===== sim/binary_to_decimal_ascii_tb.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned DecimalBase = 10;
  localparam int unsigned RandomItems = 250;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned NumRows     = 20;

  typedef struct packed {
    logic [CharWidth-1:0] ascii;
    logic                 last;
  } digit_char_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [ValueWidth-1:0] value_i;
  logic [CharWidth-1:0]  ascii_char_o;
  logic                  last_digit_o;
  logic                  result_valid_o;

  digit_char_t pending_chars[$];
  int unsigned mismatch_count = 0;
  bit          burst_mode = 1'b0;

  // Directed rows. An empty text means the row is checked against the predictor.
  logic [ValueWidth-1:0] row_value [NumRows] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999, 32'd1000000000,
    32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000, 32'h7FFFFFFF, 32'hAAAAAAAA,
    32'h55555555, 32'd12345, 32'd0, 32'd4000000000, 32'd1234567890,
    32'h0000FFFF, 32'd7
  };
  string row_text [NumRows] = '{
    "0", "1", "9", "10", "99", "100", "999999999", "1000000000",
    "4294967295", "4294967294", "2147483648", "2147483647", "",
    "", "12345", "0", "4000000000", "",
    "65535", ""
  };

  binary_to_decimal_ascii #(
    .VALUE_WIDTH(ValueWidth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .ascii_char_o  (ascii_char_o),
    .last_digit_o  (last_digit_o),
    .result_valid_o(result_valid_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Digits are gathered units first, then queued most significant first.
  function automatic void predict_decimal_text(input logic [ValueWidth-1:0] num);
    logic [3:0]            digits [10];
    int                    count;
    logic [ValueWidth-1:0] rest;
    digit_char_t           ch;
    rest  = num;
    count = 0;
    do begin
      digits[count] = 4'(rest % DecimalBase);
      count++;
      rest = rest / DecimalBase;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      ch.ascii = AsciiZero + CharWidth'(digits[k]);
      ch.last  = (k == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic void queue_typed_text(input string text);
    digit_char_t ch;
    byte         code;
    for (int i = 0; i < text.len(); i++) begin
      code     = text[i];
      ch.ascii = code[CharWidth-1:0];
      ch.last  = (i == text.len() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 35) return 0;
    else if (roll < 65) return $urandom_range(1, 3);
    else if (roll < 90) return $urandom_range(4, 50);
    else return $urandom_range(51, 120);
  endfunction

  function automatic logic [ValueWidth-1:0] random_value();
    logic [ValueWidth-1:0] power;
    power = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom >> $urandom_range(1, 31);
      7: begin
        // Values around a power of ten, where the digit count changes.
        repeat ($urandom_range(0, 9)) power = power * DecimalBase;
        return power + $urandom_range(0, 2) - 1;
      end
      8:       return $urandom_range(0, 9);
      default: return 32'hFFFFFFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  // Holds start high until the transfer is taken; returns at the accepting edge.
  task automatic send_value(input logic [ValueWidth-1:0] num);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start   <= 1'b0;
      value_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= num;
    do @(posedge clk_i); while (busy);
  endtask

  always @(posedge clk_i) begin
    digit_char_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %0d last %0b", ascii_char_o,
                                  last_digit_o));
      end else begin
        want = pending_chars.pop_front();
        if (ascii_char_o !== want.ascii)
          report_mismatch($sformatf("ascii_char got %0d want %0d", ascii_char_o,
                                    want.ascii));
        if (last_digit_o !== want.last)
          report_mismatch($sformatf("last_digit got %0b want %0b", last_digit_o,
                                    want.last));
      end
    end
  end

  initial begin
    logic [ValueWidth-1:0] num;
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      send_value(row_value[r]);
      if (row_text[r].len() == 0) predict_decimal_text(row_value[r]);
      else queue_typed_text(row_text[r]);
    end

    for (int n = 0; n < RandomItems; n++) begin
      // Every fiftieth item opens a stretch of back-to-back transfers.
      if (n % 50 == 0) burst_mode = 1'b1;
      else if (n % 50 == 20) burst_mode = 1'b0;
      num = random_value();
      send_value(num);
      predict_decimal_text(num);
    end
    start <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/b2da_pkg.sv
hdl/b2da_dpath.sv
hdl/b2da_ctrl.sv
hdl/binary_to_decimal_ascii.sv
sim/binary_to_decimal_ascii_tb.sv
